### src/vn2o_pkg.sv
// Package for the 2-D value noise octave core: widths, register codes, hash table, blend helpers.
package vn2o_pkg;

  localparam int COORD_W     = 16;
  localparam int SEED_W      = 8;
  localparam int FREQ_W      = 24;
  localparam int OCT_W       = 4;
  localparam int NOISE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int MAX_OCTAVES_DEF = 8;

  // Fixed-point position: integer bits [23:16] and fraction [15:0] are all that matter.
  localparam int POS_W  = 24;
  // Octave value in Q8.16.
  localparam int VAL_W  = 24;
  // Wide enough for a position shifted by up to fifteen octaves.
  localparam int SHIFT_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED   = 2'd0,
    REG_FREQ   = 2'd1,
    REG_OCTAVE = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] PERM [256] = '{
    8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
    8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
    8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
    8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
    8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
    8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
    8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
    8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
    8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
    8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
    8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
    8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
    8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
    8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
    8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
    8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
    8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
    8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
    8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
    8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
    8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
    8'd21,8'd88,8'd102,8'd219
  };

  // Blend two corner bytes in Q8.16; the step is exact, with no truncation.
  function automatic logic [VAL_W-1:0] lerp_byte(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [15:0] w);
    logic [VAL_W-1:0] base;
    base = {a, 16'd0};
    if (b >= a) return base + VAL_W'(w) * VAL_W'(b - a);
    else        return base - VAL_W'(w) * VAL_W'(a - b);
  endfunction

  // Blend two Q8.16 values with a Q0.16 weight.
  function automatic logic [VAL_W-1:0] lerp_val(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b,
                                                input logic [15:0] w);
    logic [VAL_W+15:0] p;
    if (b >= a) begin
      p = (VAL_W+16)'(w) * (VAL_W+16)'(b - a);
      return a + p[VAL_W+15:16];
    end else begin
      p = (VAL_W+16)'(w) * (VAL_W+16)'(a - b);
      return a - p[VAL_W+15:16];
    end
  endfunction

endpackage

### src/vn2o_in_if.sv
// Coordinate input channel.
interface vn2o_in_if;
  logic                           valid;
  logic                           ready;
  logic [vn2o_pkg::COORD_W-1:0]   coord_x;
  logic [vn2o_pkg::COORD_W-1:0]   coord_y;
  modport source (output valid, coord_x, coord_y, input ready);
  modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

### src/vn2o_out_if.sv
// Noise result channel.
interface vn2o_out_if;
  logic                           valid;
  logic                           ready;
  logic [vn2o_pkg::NOISE_W-1:0]   noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

### src/vn2o_cfg_if.sv
// Register write channel.
interface vn2o_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vn2o_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [vn2o_pkg::CFG_DATA_W-1:0]  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### src/vn2o_octave.sv
// One octave lane: four stages from scaled position to Q8.16 noise value.
module vn2o_octave #(
  parameter int K = 0
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [vn2o_pkg::POS_W-1:0]  bx,
  input  logic [vn2o_pkg::POS_W-1:0]  by,
  input  logic [vn2o_pkg::SEED_W-1:0] seed,
  output logic [vn2o_pkg::VAL_W-1:0]  noise
);

  logic [vn2o_pkg::SHIFT_W-1:0] shx, shy;
  logic [7:0]  ix, iy, iy1;
  logic [15:0] fx, fy;
  logic [31:0] sqx, sqy;

  // stage A: cell, fraction, row hashes, fraction squared
  logic [7:0]  ix_r, r0_r, r1_r;
  logic [15:0] fx_r, fy_r, s2x_r, s2y_r;

  assign shx = vn2o_pkg::SHIFT_W'(bx) << K;
  assign shy = vn2o_pkg::SHIFT_W'(by) << K;
  assign ix  = shx[23:16];
  assign iy  = shy[23:16];
  assign fx  = shx[15:0];
  assign fy  = shy[15:0];
  assign iy1 = iy + 8'd1;
  assign sqx = fx * fx;
  assign sqy = fy * fy;

  always_ff @(posedge clk) begin
    if (adv) begin
      ix_r  <= ix;
      fx_r  <= fx;
      fy_r  <= fy;
      s2x_r <= sqx[31:16];
      s2y_r <= sqy[31:16];
      r0_r  <= vn2o_pkg::PERM[iy + seed];
      r1_r  <= vn2o_pkg::PERM[iy1 + seed];
    end
  end

  // stage B: smoothstep weights, corner bytes
  logic [17:0] tx, ty;
  logic [33:0] px, py;
  logic [7:0]  ix1;
  logic [15:0] wx_r, wy_r;
  logic [7:0]  c00_r, c10_r, c01_r, c11_r;

  assign tx  = 18'd196608 - {1'b0, fx_r, 1'b0};
  assign ty  = 18'd196608 - {1'b0, fy_r, 1'b0};
  assign px  = 34'(s2x_r) * 34'(tx);
  assign py  = 34'(s2y_r) * 34'(ty);
  assign ix1 = ix_r + 8'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r  <= px[31:16];
      wy_r  <= py[31:16];
      c00_r <= vn2o_pkg::PERM[r0_r + ix_r];
      c10_r <= vn2o_pkg::PERM[r0_r + ix1];
      c01_r <= vn2o_pkg::PERM[r1_r + ix_r];
      c11_r <= vn2o_pkg::PERM[r1_r + ix1];
    end
  end

  // stage C: blend along x
  logic [vn2o_pkg::VAL_W-1:0] lo_r, hi_r;
  logic [15:0] wy2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r  <= vn2o_pkg::lerp_byte(c00_r, c10_r, wx_r);
      hi_r  <= vn2o_pkg::lerp_byte(c01_r, c11_r, wx_r);
      wy2_r <= wy_r;
    end
  end

  // stage D: blend along y
  logic [vn2o_pkg::VAL_W-1:0] noise_r;

  always_ff @(posedge clk) begin
    if (adv) noise_r <= vn2o_pkg::lerp_val(lo_r, hi_r, wy2_r);
  end

  assign noise = noise_r;

endmodule

### src/value_noise_2d_octaves_core.sv
// Two-dimensional value noise summed over octaves; top level of the pipeline.
//
// Takes one coordinate beat per cycle while the output is not stalled and
// returns one Q0.16 noise beat per input, in order. The pipeline is: scaling
// multiply (1 stage), one four-stage lane per octave running in parallel, a
// two-stage weighted sum, and a 16-stage restoring quotient pipeline that
// divides by 256 * (2^n - 1). A stall on the result side freezes every stage,
// so beats are held, never dropped. Registers: seed, frequency (Q8.16) and
// octave count (saturated to MAX_OCTAVES; zero yields 0); write them only
// while no beat is in flight. Register writes are always accepted; writes to
// an unused index are dropped.
module value_noise_2d_octaves_core #(
  parameter int MAX_OCTAVES = vn2o_pkg::MAX_OCTAVES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  vn2o_in_if.sink        in_ch,
  vn2o_out_if.source     out_ch,
  vn2o_cfg_if.sink       cfg_ch
);

  localparam int NW    = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W = vn2o_pkg::VAL_W + MAX_OCTAVES;
  localparam int RW    = ACC_W - 8;
  localparam int QW    = vn2o_pkg::NOISE_W;
  localparam int NP    = (MAX_OCTAVES + 1) / 2;
  localparam int LAT   = 7 + QW;

  // ---------------- configuration registers ----------------
  logic [vn2o_pkg::SEED_W-1:0] seed_r;
  logic [vn2o_pkg::FREQ_W-1:0] freq_r;
  logic [vn2o_pkg::OCT_W-1:0]  oct_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      freq_r <= vn2o_pkg::FREQ_W'(6554);
      oct_r  <= vn2o_pkg::OCT_W'(4);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        vn2o_pkg::REG_SEED:   seed_r <= cfg_ch.wdata[vn2o_pkg::SEED_W-1:0];
        vn2o_pkg::REG_FREQ:   freq_r <= cfg_ch.wdata[vn2o_pkg::FREQ_W-1:0];
        vn2o_pkg::REG_OCTAVE: oct_r  <= cfg_ch.wdata[vn2o_pkg::OCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective octave count and divisor; the user must keep them stable while beats are in flight.
  logic [NW-1:0]          n_oct;
  logic [MAX_OCTAVES-1:0] divisor;
  logic                   n_zero;

  always_comb begin
    if (32'(oct_r) > 32'(MAX_OCTAVES)) n_oct = NW'(MAX_OCTAVES);
    else                               n_oct = NW'(oct_r);
  end
  assign divisor = MAX_OCTAVES'((33'd1 << n_oct) - 33'd1);
  assign n_zero  = (n_oct == '0);

  // ---------------- pipeline control ----------------
  // Advance every stage unless the output holds a beat nobody takes.
  logic           adv;
  logic [LAT-1:0] v_r;

  assign adv         = !v_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[LAT-2:0], in_ch.valid};
  end

  // ---------------- scaling multiply ----------------
  // Only the low 24 bits of the scaled position feed any octave.
  logic [vn2o_pkg::POS_W-1:0] bx_r, by_r;
  logic [39:0] mx, my;

  assign mx = 40'(in_ch.coord_x) * 40'(freq_r);
  assign my = 40'(in_ch.coord_y) * 40'(freq_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      bx_r <= mx[vn2o_pkg::POS_W-1:0];
      by_r <= my[vn2o_pkg::POS_W-1:0];
    end
  end

  // ---------------- octave lanes ----------------
  logic [vn2o_pkg::VAL_W-1:0] lane_val [MAX_OCTAVES];

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    vn2o_octave #(.K(k)) u_oct (
      .clk   (clk),
      .adv   (adv),
      .bx    (bx_r),
      .by    (by_r),
      .seed  (seed_r),
      .noise (lane_val[k])
    );
  end

  // ---------------- weighted sum ----------------
  // Octave k is shifted up by n-1-k; lanes past the count contribute nothing.
  logic [ACC_W-1:0] term [MAX_OCTAVES];
  logic [ACC_W-1:0] pair_r [NP];

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_term
    always_comb begin
      if (k < n_oct) term[k] = ACC_W'(lane_val[k]) << (n_oct - NW'(k) - NW'(1));
      else           term[k] = '0;
    end
  end

  for (genvar p = 0; p < NP; p++) begin : g_pair
    if (2 * p + 1 < MAX_OCTAVES) begin : g_two
      always_ff @(posedge clk) begin
        if (adv) pair_r[p] <= term[2*p] + term[2*p+1];
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        if (adv) pair_r[p] <= term[2*p];
      end
    end
  end

  logic [ACC_W-1:0] acc;
  logic [RW-1:0]    rem0_r;

  always_comb begin
    acc = '0;
    for (int p = 0; p < NP; p++) acc = acc + pair_r[p];
  end

  // Drop the factor 256 first; floor division composes.
  always_ff @(posedge clk) begin
    if (adv) rem0_r <= acc[ACC_W-1:8];
  end

  // ---------------- quotient pipeline ----------------
  // One quotient bit per stage, most significant first; the quotient fits 16 bits.
  logic [RW-1:0] rem_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] rem_in, dsh;
    logic [QW-1:0] q_in;
    if (j == 0) begin : g_first
      assign rem_in = rem0_r;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
    end
    assign dsh = RW'(divisor) << (QW - 1 - j);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= dsh) begin
          rem_r[j] <= rem_in - dsh;
          q_r[j]   <= q_in | (QW'(1) << (QW - 1 - j));
        end else begin
          rem_r[j] <= rem_in;
          q_r[j]   <= q_in;
        end
      end
    end
  end

  // ---------------- result ----------------
  assign out_ch.valid       = v_r[LAT-1];
  assign out_ch.noise_value = n_zero ? '0 : q_r[QW-1];

  // ---------------- checks ----------------
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline moved while stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted beat missing from first stage");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.noise_value <= 16'd65280)
    else $error("noise value above full scale");

endmodule
